FILE: rtl/dtq_pkg.sv
// Types and codes shared by the delta-list timer queue.
// No dependencies.
package dtq_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_ERASE  = 2'd1;
    localparam logic [1:0] REQ_DEC    = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_DEC    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] client_id;
        logic [15:0] wait_time;
        logic [7:0]  position;
        logic [15:0] tick_amount;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        has_expired;
        logic [15:0] expired_client;
        logic        last;
        logic [4:0]  entry_count;
        logic [15:0] expired_total;
        logic        head_zero;
    } rsp_item_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] client_id;
        logic [15:0] wait_time;
        logic [7:0]  position;
        logic [15:0] tick_amount;
    } cmd_t;

endpackage

FILE: rtl/dtq_front.sv
// Request intake: decodes each request and holds it in a two-entry queue.
// Depends on dtq_pkg.
module dtq_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dtq_pkg::req_item_t req_data,
    output logic               cmd_valid,
    input  logic               cmd_pop,
    output dtq_pkg::cmd_t      cmd
);

    dtq_pkg::cmd_t q_reg [2];
    logic [1:0]    fill_reg, fill_next;
    logic          wr_reg, wr_next;
    logic          rd_reg, rd_next;
    logic          push;
    dtq_pkg::cmd_t decoded;

    always_comb
    begin
        case (req_data.req_type)
            dtq_pkg::REQ_INSERT: decoded.kind = dtq_pkg::CMD_INSERT;
            dtq_pkg::REQ_ERASE:  decoded.kind = dtq_pkg::CMD_ERASE;
            dtq_pkg::REQ_DEC:    decoded.kind = dtq_pkg::CMD_DEC;
            default:             decoded.kind = dtq_pkg::CMD_NOP;
        endcase
        decoded.client_id   = req_data.client_id;
        decoded.wait_time   = req_data.wait_time;
        decoded.position    = req_data.position;
        decoded.tick_amount = req_data.tick_amount;
    end

    assign req_stall = (fill_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? !wr_reg : wr_reg;
        rd_next   = cmd_pop ? !rd_reg : rd_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= decoded;
        end
    end

endmodule

FILE: rtl/dtq_back.sv
// List engine: walks and edits the delta list, emits results.
// Depends on dtq_pkg.
module dtq_back
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  dtq_pkg::cmd_t      cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dtq_pkg::rsp_item_t rsp_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INS   = 7'b0000010,
        S_ERASE = 7'b0000100,
        S_DEC   = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_POP   = 7'b0100000,
        S_RES   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    dtq_pkg::cmd_t      op_reg, op_next;
    logic [CW-1:0]      cursor_reg, cursor_next;
    logic [15:0]        rem_reg, rem_next;
    logic [1:0]         status_reg, status_next;
    logic [CW-1:0]      gone_reg, gone_next;
    logic [CW-1:0]      emit_reg, emit_next;
    logic [CW-1:0]      fin_count_reg, fin_count_next;
    logic [15:0]        fin_total_reg, fin_total_next;
    logic               fin_hz_reg, fin_hz_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [15:0]        expired_reg, expired_next;
    logic               out_valid_reg, out_valid_next;
    dtq_pkg::rsp_item_t out_data_reg, out_data_next;
    logic [15:0]        tag_reg [CAPACITY];
    logic [15:0]        tag_next [CAPACITY];
    logic [15:0]        delta_reg [CAPACITY];
    logic [15:0]        delta_next [CAPACITY];

    logic               can_put;
    logic               cur_in;
    logic [15:0]        cur_delta;
    logic [IW-1:0]      erase_idx;
    logic [16:0]        fold_sum;
    logic [16:0]        total_sum;
    logic [31:0]        count32;
    logic [31:0]        fin_count32;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;
    assign count32     = 32'(count_reg);
    assign fin_count32 = 32'(fin_count_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cursor_next    = cursor_reg;
        rem_next       = rem_reg;
        status_next    = status_reg;
        gone_next      = gone_reg;
        emit_next      = emit_reg;
        fin_count_next = fin_count_reg;
        fin_total_next = fin_total_reg;
        fin_hz_next    = fin_hz_reg;
        count_next     = count_reg;
        expired_next   = expired_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        tag_next       = tag_reg;
        delta_next     = delta_reg;
        cmd_pop        = 1'b0;
        fold_sum       = 17'd0;

        can_put   = !out_valid_reg || !rsp_stall;
        cur_in    = (cursor_reg < count_reg);
        cur_delta = delta_reg[cursor_reg[IW-1:0]];
        erase_idx = IW'(op_reg.position - 8'd1);
        total_sum = {1'b0, expired_reg} + 17'(cursor_reg);

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    op_next     = cmd;
                    cursor_next = '0;
                    status_next = dtq_pkg::ST_OK;
                    case (cmd.kind)
                        dtq_pkg::CMD_INSERT:
                        begin
                            rem_next = cmd.wait_time;
                            if (32'(count_reg) == CAPACITY)
                            begin
                                status_next = dtq_pkg::ST_FULL;
                                state_next  = S_RES;
                            end
                            else
                            begin
                                state_next = S_INS;
                            end
                        end
                        dtq_pkg::CMD_ERASE:
                        begin
                            if (cmd.position == 8'd0 || 32'(cmd.position) > count32)
                            begin
                                status_next = dtq_pkg::ST_BADPOS;
                                state_next  = S_RES;
                            end
                            else
                            begin
                                state_next = S_ERASE;
                            end
                        end
                        dtq_pkg::CMD_DEC:
                        begin
                            rem_next   = cmd.tick_amount;
                            state_next = S_DEC;
                        end
                        default:
                        begin
                            state_next = S_RES;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                if (cur_in && rem_reg >= cur_delta)
                begin
                    rem_next    = rem_reg - cur_delta;
                    cursor_next = cursor_reg + 1'b1;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (i > 32'(cursor_reg))
                        begin
                            tag_next[i]   = tag_reg[(i > 0) ? i - 1 : 0];
                            delta_next[i] = delta_reg[(i > 0) ? i - 1 : 0];
                        end
                        // old entry at the insert point gives up the new wait
                        if (i == 32'(cursor_reg) + 1)
                        begin
                            delta_next[i] = delta_reg[(i > 0) ? i - 1 : 0] - rem_reg;
                        end
                        if (i == 32'(cursor_reg))
                        begin
                            tag_next[i]   = op_reg.client_id;
                            delta_next[i] = rem_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                    state_next = S_RES;
                end
            end

            S_ERASE:
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (i >= 32'(erase_idx))
                    begin
                        tag_next[i]   = tag_reg[i + 1];
                        delta_next[i] = delta_reg[i + 1];
                    end
                    if (i == 32'(erase_idx))
                    begin
                        fold_sum      = {1'b0, delta_reg[i + 1]} + {1'b0, delta_reg[i]};
                        delta_next[i] = fold_sum[16] ? 16'hFFFF : fold_sum[15:0];
                    end
                end
                count_next = count_reg - 1'b1;
                state_next = S_RES;
            end

            S_DEC:
            begin
                if (cur_in && cur_delta < rem_reg)
                begin
                    rem_next    = rem_reg - cur_delta;
                    cursor_next = cursor_reg + 1'b1;
                end
                else
                begin
                    gone_next      = cursor_reg;
                    emit_next      = '0;
                    fin_count_next = count_reg - cursor_reg;
                    fin_total_next = total_sum[16] ? 16'hFFFF : total_sum[15:0];
                    fin_hz_next    = cur_in && (cur_delta == rem_reg);
                    state_next     = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (can_put)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = dtq_pkg::ST_OK;
                    out_data_next.entry_count    = fin_count32[4:0];
                    out_data_next.expired_total  = fin_total_reg;
                    out_data_next.head_zero      = fin_hz_reg;
                    if (gone_reg == '0)
                    begin
                        out_data_next.has_expired    = 1'b0;
                        out_data_next.expired_client = 16'd0;
                        out_data_next.last           = 1'b1;
                        state_next                   = S_POP;
                    end
                    else
                    begin
                        out_data_next.has_expired    = 1'b1;
                        out_data_next.expired_client = tag_reg[emit_reg[IW-1:0]];
                        out_data_next.last           = (emit_reg + 1'b1 == gone_reg);
                        emit_next                    = emit_reg + 1'b1;
                        if (emit_reg + 1'b1 == gone_reg)
                        begin
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_POP:
            begin
                // drop expired heads one a cycle, then charge the leftover to the head
                if (gone_reg != '0)
                begin
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        tag_next[i]   = tag_reg[i + 1];
                        delta_next[i] = delta_reg[i + 1];
                    end
                    count_next = count_reg - 1'b1;
                    gone_next  = gone_reg - 1'b1;
                end
                else
                begin
                    if (count_reg != '0)
                    begin
                        delta_next[0] = delta_reg[0] - rem_reg;
                    end
                    expired_next = fin_total_reg;
                    state_next   = S_IDLE;
                end
            end

            S_RES:
            begin
                if (can_put)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = status_reg;
                    out_data_next.has_expired    = 1'b0;
                    out_data_next.expired_client = 16'd0;
                    out_data_next.last           = 1'b1;
                    out_data_next.entry_count    = count32[4:0];
                    out_data_next.expired_total  = expired_reg;
                    out_data_next.head_zero      = (count_reg != '0) && (delta_reg[0] == 16'd0);
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            expired_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            expired_reg   <= expired_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        cursor_reg    <= cursor_next;
        rem_reg       <= rem_next;
        status_reg    <= status_next;
        gone_reg      <= gone_next;
        emit_reg      <= emit_next;
        fin_count_reg <= fin_count_next;
        fin_total_reg <= fin_total_next;
        fin_hz_reg    <= fin_hz_next;
        out_data_reg  <= out_data_next;
        tag_reg       <= tag_next;
        delta_reg     <= delta_next;
    end

endmodule

FILE: rtl/delta_timer_queue.sv
// Delta-list timer queue, top level. Insert walks the list, comparing one list entry
// per cycle.
// One request is worked at a time; a two-entry request queue keeps intake open.
// Reset (rst_n, async low) empties the list and clears the expired count.
// Depends on dtq_pkg, dtq_front, dtq_back.
module delta_timer_queue
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dtq_pkg::req_item_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dtq_pkg::rsp_item_t rsp_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    dtq_pkg::cmd_t cmd;

    dtq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    dtq_back #(.CAPACITY(CAPACITY)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

FILE: rtl/dtq_checker.sv
// Port-level checks for delta_timer_queue, attached by bind.
// Depends on dtq_pkg.
module dtq_checker
#(
    parameter int CAPACITY = 16
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input dtq_pkg::req_item_t req_data,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input dtq_pkg::rsp_item_t rsp_data
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
        else $error("stalled request changed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_data.entry_count) <= CAPACITY)
        else $error("entry count above capacity");

    a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.has_expired |-> rsp_data.status == dtq_pkg::ST_OK)
        else $error("expired tag with error status");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.has_expired |-> rsp_data.last)
        else $error("plain result not marked last");

endmodule

bind delta_timer_queue dtq_checker #(.CAPACITY(CAPACITY)) u_dtq_checker (.*);
